// ===== rtl/mbw_pkg.sv =====
`timescale 1ns / 1ps

package mbw_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int StackDepth = 4096;

  localparam int CoordW    = 6;
  localparam int SizeW     = 7;
  localparam int PermW     = 5;
  localparam int CodeW     = 3;
  localparam int PendW     = 13;
  localparam int PermCount = 24;

  localparam int CellDepth = MaxWidth * MaxHeight;
  localparam int CellAw    = $clog2(CellDepth);
  localparam int StkAw     = $clog2(StackDepth);
  localparam int CntW      = $clog2(StackDepth + 1);

  localparam int PAddrW = 3;
  localparam int DataW  = 32;

  typedef enum logic [1:0] {
    DIR_NORTH,
    DIR_SOUTH,
    DIR_EAST,
    DIR_WEST
  } dir_e;

  typedef enum logic {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT
  } reg_e;

  localparam logic [CodeW-1:0] CODE_UNVISITED = 3'd0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_POP,
    ST_TASK,
    ST_DST_CHK,
    ST_SRC_CHK,
    ST_WR_DST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              is_carve;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    dir_e              dir;
  } task_t;

  typedef struct packed {
    logic              rd_en;
    logic [CellAw-1:0] rd_addr;
    logic              wr_en;
    logic [CellAw-1:0] wr_addr;
    logic [CodeW-1:0]  wr_data;
  } cell_req_t;

  typedef struct packed {
    logic [SizeW-1:0] x;
    logic [SizeW-1:0] y;
  } point_t;

  // Direction order of one expansion; element k sits at bits [2k+1:2k].
  function automatic logic [7:0] perm_order(logic [PermW-1:0] p);
    case (p)
      5'd0:    return {2'd3, 2'd2, 2'd1, 2'd0};
      5'd1:    return {2'd2, 2'd3, 2'd1, 2'd0};
      5'd2:    return {2'd3, 2'd1, 2'd2, 2'd0};
      5'd3:    return {2'd1, 2'd3, 2'd2, 2'd0};
      5'd4:    return {2'd2, 2'd1, 2'd3, 2'd0};
      5'd5:    return {2'd1, 2'd2, 2'd3, 2'd0};
      5'd6:    return {2'd3, 2'd2, 2'd0, 2'd1};
      5'd7:    return {2'd2, 2'd3, 2'd0, 2'd1};
      5'd8:    return {2'd3, 2'd0, 2'd2, 2'd1};
      5'd9:    return {2'd0, 2'd3, 2'd2, 2'd1};
      5'd10:   return {2'd2, 2'd0, 2'd3, 2'd1};
      5'd11:   return {2'd0, 2'd2, 2'd3, 2'd1};
      5'd12:   return {2'd3, 2'd1, 2'd0, 2'd2};
      5'd13:   return {2'd1, 2'd3, 2'd0, 2'd2};
      5'd14:   return {2'd3, 2'd0, 2'd1, 2'd2};
      5'd15:   return {2'd0, 2'd3, 2'd1, 2'd2};
      5'd16:   return {2'd1, 2'd0, 2'd3, 2'd2};
      5'd17:   return {2'd0, 2'd1, 2'd3, 2'd2};
      5'd18:   return {2'd2, 2'd1, 2'd0, 2'd3};
      5'd19:   return {2'd1, 2'd2, 2'd0, 2'd3};
      5'd20:   return {2'd2, 2'd0, 2'd1, 2'd3};
      5'd21:   return {2'd0, 2'd2, 2'd1, 2'd3};
      5'd22:   return {2'd1, 2'd0, 2'd2, 2'd3};
      5'd23:   return {2'd0, 2'd1, 2'd2, 2'd3};
      default: return {2'd3, 2'd2, 2'd1, 2'd0};
    endcase
  endfunction

  function automatic logic [CodeW-1:0] dir_code(dir_e d);
    return {1'b0, d} + CodeW'(1);
  endfunction

  function automatic logic [CodeW-1:0] opposite_code(dir_e d);
    case (d)
      DIR_NORTH: return dir_code(DIR_SOUTH);
      DIR_SOUTH: return dir_code(DIR_NORTH);
      DIR_EAST:  return dir_code(DIR_WEST);
      DIR_WEST:  return dir_code(DIR_EAST);
      default:   return CODE_UNVISITED;
    endcase
  endfunction

  // A step off the low edge wraps to the top of the 7-bit range and so
  // falls outside every legal grid size.
  function automatic point_t neighbor(logic [CoordW-1:0] x, logic [CoordW-1:0] y, dir_e d);
    point_t p;
    p.x = {1'b0, x};
    p.y = {1'b0, y};
    case (d)
      DIR_NORTH: p.y = p.y - SizeW'(1);
      DIR_SOUTH: p.y = p.y + SizeW'(1);
      DIR_EAST:  p.x = p.x + SizeW'(1);
      DIR_WEST:  p.x = p.x - SizeW'(1);
      default:   p = p;
    endcase
    return p;
  endfunction

  function automatic logic [CellAw-1:0] cell_addr(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    return CellAw'(CellAw'(y) * CellAw'(MaxWidth) + CellAw'(x));
  endfunction

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] s, logic [SizeW-1:0] lim);
    if (s == '0) begin
      return SizeW'(1);
    end else if (s > lim) begin
      return lim;
    end
    return s;
  endfunction

endpackage

// ===== rtl/mbw_if.sv =====
`timescale 1ns / 1ps

interface mbw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [mbw_pkg::PermW-1:0]    perm;
  logic [mbw_pkg::CoordW-1:0]   cell_x;
  logic [mbw_pkg::CoordW-1:0]   cell_y;

  modport source(output valid, func, perm, cell_x, cell_y, input ready);
  modport sink(input valid, func, perm, cell_x, cell_y, output ready);
endinterface

interface mbw_out_if;
  logic                         valid;
  logic                         ready;
  logic                         changed;
  logic                         source_marked;
  logic [mbw_pkg::CoordW-1:0]   source_x;
  logic [mbw_pkg::CoordW-1:0]   source_y;
  logic [mbw_pkg::CoordW-1:0]   dest_x;
  logic [mbw_pkg::CoordW-1:0]   dest_y;
  logic [mbw_pkg::CodeW-1:0]    cell_value;
  logic [mbw_pkg::PendW-1:0]    pending_tasks;
  logic                         finished;

  modport source(output valid, changed, source_marked, source_x, source_y, dest_x, dest_y,
                 cell_value, pending_tasks, finished, input ready);
  modport sink(input valid, changed, source_marked, source_x, source_y, dest_x, dest_y,
               cell_value, pending_tasks, finished, output ready);
endinterface

// ===== rtl/mbw_grid_store.sv =====
`timescale 1ns / 1ps

module mbw_grid_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbw_pkg::cell_req_t            req_i,
  output logic [mbw_pkg::CodeW-1:0]     rd_data_o,
  output logic                          busy_o
);

  logic [mbw_pkg::CodeW-1:0]  mem [mbw_pkg::CellDepth];
  logic [mbw_pkg::CellAw-1:0] clr_q, clr_d;
  logic                       busy_q, busy_d;
  logic [mbw_pkg::CodeW-1:0]  rd_data_q;

  // After reset every cell is swept to the unvisited code, one per cycle.
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + mbw_pkg::CellAw'(1);
      if (clr_q == mbw_pkg::CellAw'(mbw_pkg::CellDepth - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= mbw_pkg::CODE_UNVISITED;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

// ===== rtl/maze_backtracker_walk_top.sv =====
`timescale 1ns / 1ps

// Depth-first maze carver over a 64 by 64 cell store with a 4096-entry task stack,
// both held in memories with registered read ports. After reset the cell store is
// swept clear, and meanwhile no transaction is taken on the input channel (register
// writes are taken). One item is worked on at a time. A read item issues its cell
// read when taken, captures the value in ST_READ and hands it over in ST_DONE. A
// tick walks the stack: each task is popped in ST_POP and ST_TASK, an expansion
// checks each direction in ST_EXP_RD and ST_EXP_CHK on the cell read port, a failed
// carve goes back to ST_POP at once when its target is off the grid or after
// ST_DST_CHK when the target is already visited, and the successful carve passes
// ST_DST_CHK, ST_SRC_CHK and ST_WR_DST before ST_DONE hands over the result. The
// result sits in an output register, so the next item is accepted while it waits.
module maze_backtracker_walk_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mbw_in_if.sink                       in_i,
  mbw_out_if.source                    out_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mbw_pkg::PAddrW-1:0]   paddr_i,
  input  logic [mbw_pkg::DataW-1:0]    pwdata_i,
  output logic [mbw_pkg::DataW-1:0]    prdata_o,
  output logic                         pready_o
);

  localparam int CW = mbw_pkg::CoordW;
  localparam int SW = mbw_pkg::SizeW;
  localparam int NW = mbw_pkg::CntW;

  mbw_pkg::state_e state_q, state_d;

  logic                        first_q, first_d;
  logic                        exp_only_q, exp_only_d;
  logic [mbw_pkg::PermW-1:0]   perm_q, perm_d;
  logic [1:0]                  k_q, k_d;
  logic [CW-1:0]               cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  mbw_pkg::dir_e               dir_q, dir_d;
  logic [CW-1:0]               nb_x_q, nb_x_d, nb_y_q, nb_y_d;
  logic                        nb_ok_q, nb_ok_d;
  logic [NW-1:0]               cnt_q, cnt_d;
  logic                        chg_q, chg_d, smark_q, smark_d;
  logic [CW-1:0]               sx_q, sx_d, sy_q, sy_d, dx_q, dx_d, dy_q, dy_d;
  logic [mbw_pkg::CodeW-1:0]   cval_q, cval_d;
  logic [SW-1:0]               gw_q, gh_q;

  logic                        ovalid_q, ovalid_d;
  logic                        o_chg_q, o_smark_q, o_fin_q;
  logic [CW-1:0]               o_sx_q, o_sy_q, o_dx_q, o_dy_q;
  logic [mbw_pkg::CodeW-1:0]   o_cval_q;
  logic [mbw_pkg::PendW-1:0]   o_pend_q;
  logic                        o_load;

  mbw_pkg::cell_req_t          cell_req;
  logic [mbw_pkg::CodeW-1:0]   cell_rd;
  logic                        grid_busy;

  mbw_pkg::task_t              stk_mem [mbw_pkg::StackDepth];
  mbw_pkg::task_t              stk_rd_q, stk_wdata;
  logic                        stk_we, stk_re;
  logic [mbw_pkg::StkAw-1:0]   stk_waddr, stk_raddr;
  logic [NW-1:0]               cnt_dec;

  logic                        in_fire, cfg_wr;
  logic [SW-1:0]               aw, ah;
  logic [7:0]                  order;
  mbw_pkg::dir_e               exp_dir, task_dir;
  mbw_pkg::point_t             exp_nb, task_nb;
  logic                        stk_full, no_tasks;
  logic [NW+mbw_pkg::PendW-1:0] pend_ext;

  mbw_grid_store u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cell_req),
    .rd_data_o (cell_rd),
    .busy_o    (grid_busy)
  );

  assign in_i.ready = (state_q == mbw_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Configuration port.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= SW'(64);
      gh_q <= SW'(64);
    end else if (cfg_wr) begin
      if (paddr_i[2] == mbw_pkg::REG_GRID_WIDTH) begin
        gw_q <= pwdata_i[SW-1:0];
      end else begin
        gh_q <= pwdata_i[SW-1:0];
      end
    end
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == mbw_pkg::REG_GRID_WIDTH) begin
      prdata_o[SW-1:0] = gw_q;
    end else begin
      prdata_o[SW-1:0] = gh_q;
    end
  end

  assign aw = mbw_pkg::clamp_size(gw_q, SW'(mbw_pkg::MaxWidth));
  assign ah = mbw_pkg::clamp_size(gh_q, SW'(mbw_pkg::MaxHeight));

  assign order    = mbw_pkg::perm_order(perm_q);
  assign exp_dir  = mbw_pkg::dir_e'(order[{k_q, 1'b0} +: 2]);
  assign exp_nb   = mbw_pkg::neighbor(cur_x_q, cur_y_q, exp_dir);
  assign task_dir = stk_rd_q.dir;
  assign task_nb  = mbw_pkg::neighbor(stk_rd_q.x, stk_rd_q.y, task_dir);
  assign stk_full = (cnt_q == NW'(mbw_pkg::StackDepth));
  assign no_tasks = (cnt_q == '0);
  assign cnt_dec  = cnt_q - NW'(1);
  assign o_load   = (state_q == mbw_pkg::ST_DONE) && (!ovalid_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbw_pkg::ST_CLEAR: begin
        if (!grid_busy) state_d = mbw_pkg::ST_IDLE;
      end
      mbw_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.func) begin
            state_d = mbw_pkg::ST_READ;
          end else if (first_q) begin
            state_d = mbw_pkg::ST_EXP_RD;
          end else begin
            state_d = mbw_pkg::ST_POP;
          end
        end
      end
      mbw_pkg::ST_READ:   state_d = mbw_pkg::ST_DONE;
      mbw_pkg::ST_EXP_RD: state_d = mbw_pkg::ST_EXP_CHK;
      mbw_pkg::ST_EXP_CHK: begin
        if (k_q != 2'd3) begin
          state_d = mbw_pkg::ST_EXP_RD;
        end else if (exp_only_q) begin
          state_d = mbw_pkg::ST_DONE;
        end else begin
          state_d = mbw_pkg::ST_POP;
        end
      end
      mbw_pkg::ST_POP: begin
        state_d = no_tasks ? mbw_pkg::ST_DONE : mbw_pkg::ST_TASK;
      end
      mbw_pkg::ST_TASK: begin
        if (!stk_rd_q.is_carve) begin
          state_d = mbw_pkg::ST_EXP_RD;
        end else if (task_nb.x < aw && task_nb.y < ah) begin
          state_d = mbw_pkg::ST_DST_CHK;
        end else begin
          state_d = mbw_pkg::ST_POP;
        end
      end
      mbw_pkg::ST_DST_CHK: begin
        state_d = (cell_rd == mbw_pkg::CODE_UNVISITED) ? mbw_pkg::ST_SRC_CHK : mbw_pkg::ST_POP;
      end
      mbw_pkg::ST_SRC_CHK: state_d = mbw_pkg::ST_WR_DST;
      mbw_pkg::ST_WR_DST:  state_d = mbw_pkg::ST_DONE;
      mbw_pkg::ST_DONE: begin
        if (o_load) state_d = mbw_pkg::ST_IDLE;
      end
      default: state_d = mbw_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    first_d    = first_q;
    exp_only_d = exp_only_q;
    perm_d     = perm_q;
    k_d        = k_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    dir_d      = dir_q;
    nb_x_d     = nb_x_q;
    nb_y_d     = nb_y_q;
    nb_ok_d    = nb_ok_q;
    cnt_d      = cnt_q;
    chg_d      = chg_q;
    smark_d    = smark_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    cval_d     = cval_q;
    cell_req   = '0;
    stk_we     = 1'b0;
    stk_waddr  = cnt_q[mbw_pkg::StkAw-1:0];
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = cnt_dec[mbw_pkg::StkAw-1:0];

    case (state_q)
      mbw_pkg::ST_IDLE: begin
        if (in_fire) begin
          chg_d   = 1'b0;
          smark_d = 1'b0;
          sx_d    = '0;
          sy_d    = '0;
          dx_d    = '0;
          dy_d    = '0;
          cval_d  = mbw_pkg::CODE_UNVISITED;
          k_d     = '0;
          perm_d  = (in_i.perm >= mbw_pkg::PermW'(mbw_pkg::PermCount))
                    ? in_i.perm - mbw_pkg::PermW'(mbw_pkg::PermCount) : in_i.perm;
          if (in_i.func) begin
            nb_ok_d          = ({1'b0, in_i.cell_x} < SW'(mbw_pkg::MaxWidth)) &&
                               ({1'b0, in_i.cell_y} < SW'(mbw_pkg::MaxHeight));
            cell_req.rd_en   = 1'b1;
            cell_req.rd_addr = mbw_pkg::cell_addr(in_i.cell_x, in_i.cell_y);
          end else if (first_q) begin
            first_d    = 1'b0;
            exp_only_d = 1'b1;
            cur_x_d    = '0;
            cur_y_d    = '0;
          end else begin
            exp_only_d = 1'b0;
          end
        end
      end
      mbw_pkg::ST_READ: begin
        cval_d = nb_ok_q ? cell_rd : mbw_pkg::CODE_UNVISITED;
      end
      mbw_pkg::ST_EXP_RD: begin
        nb_ok_d          = (exp_nb.x < aw) && (exp_nb.y < ah);
        dir_d            = exp_dir;
        cell_req.rd_en   = 1'b1;
        cell_req.rd_addr = mbw_pkg::cell_addr(exp_nb.x[CW-1:0], exp_nb.y[CW-1:0]);
      end
      mbw_pkg::ST_EXP_CHK: begin
        k_d = k_q + 2'd1;
        if (nb_ok_q && cell_rd == mbw_pkg::CODE_UNVISITED && !stk_full) begin
          stk_we             = 1'b1;
          stk_wdata.is_carve = 1'b1;
          stk_wdata.x        = cur_x_q;
          stk_wdata.y        = cur_y_q;
          stk_wdata.dir      = dir_q;
          cnt_d              = cnt_q + NW'(1);
        end
      end
      mbw_pkg::ST_POP: begin
        if (!no_tasks) begin
          stk_re = 1'b1;
          cnt_d  = cnt_dec;
        end
      end
      mbw_pkg::ST_TASK: begin
        cur_x_d = stk_rd_q.x;
        cur_y_d = stk_rd_q.y;
        dir_d   = task_dir;
        k_d     = '0;
        nb_x_d  = task_nb.x[CW-1:0];
        nb_y_d  = task_nb.y[CW-1:0];
        if (stk_rd_q.is_carve) begin
          cell_req.rd_en   = 1'b1;
          cell_req.rd_addr = mbw_pkg::cell_addr(task_nb.x[CW-1:0], task_nb.y[CW-1:0]);
        end
      end
      mbw_pkg::ST_DST_CHK: begin
        cell_req.rd_en   = 1'b1;
        cell_req.rd_addr = mbw_pkg::cell_addr(cur_x_q, cur_y_q);
      end
      mbw_pkg::ST_SRC_CHK: begin
        if (cell_rd == mbw_pkg::CODE_UNVISITED) begin
          cell_req.wr_en   = 1'b1;
          cell_req.wr_addr = mbw_pkg::cell_addr(cur_x_q, cur_y_q);
          cell_req.wr_data = mbw_pkg::dir_code(dir_q);
          smark_d          = 1'b1;
          sx_d             = cur_x_q;
          sy_d             = cur_y_q;
        end
      end
      mbw_pkg::ST_WR_DST: begin
        cell_req.wr_en   = 1'b1;
        cell_req.wr_addr = mbw_pkg::cell_addr(nb_x_q, nb_y_q);
        cell_req.wr_data = mbw_pkg::opposite_code(dir_q);
        chg_d            = 1'b1;
        dx_d             = nb_x_q;
        dy_d             = nb_y_q;
        if (!stk_full) begin
          stk_we             = 1'b1;
          stk_wdata.is_carve = 1'b0;
          stk_wdata.x        = nb_x_q;
          stk_wdata.y        = nb_y_q;
          stk_wdata.dir      = mbw_pkg::DIR_NORTH;
          cnt_d              = cnt_q + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (o_load) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mbw_pkg::ST_CLEAR;
      first_q    <= 1'b1;
      exp_only_q <= 1'b0;
      cnt_q      <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      first_q    <= first_d;
      exp_only_q <= exp_only_d;
      cnt_q      <= cnt_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    perm_q  <= perm_d;
    k_q     <= k_d;
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    dir_q   <= dir_d;
    nb_x_q  <= nb_x_d;
    nb_y_q  <= nb_y_d;
    nb_ok_q <= nb_ok_d;
    chg_q   <= chg_d;
    smark_q <= smark_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    cval_q  <= cval_d;
  end

  assign pend_ext = {{mbw_pkg::PendW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_chg_q   <= chg_q;
      o_smark_q <= smark_q;
      o_sx_q    <= sx_q;
      o_sy_q    <= sy_q;
      o_dx_q    <= dx_q;
      o_dy_q    <= dy_q;
      o_cval_q  <= cval_q;
      o_pend_q  <= pend_ext[mbw_pkg::PendW-1:0];
      o_fin_q   <= !first_q && no_tasks;
    end
  end

  // Task stack memory.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.changed       = o_chg_q;
  assign out_o.source_marked = o_smark_q;
  assign out_o.source_x      = o_sx_q;
  assign out_o.source_y      = o_sy_q;
  assign out_o.dest_x        = o_dx_q;
  assign out_o.dest_y        = o_dy_q;
  assign out_o.cell_value    = o_cval_q;
  assign out_o.pending_tasks = o_pend_q;
  assign out_o.finished      = o_fin_q;

  // The stack never holds more than its depth and moves by one task at most per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(mbw_pkg::StackDepth))
    else $error("task count above stack depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + NW'(1) ||
              cnt_q == $past(cnt_q) - NW'(1)))
    else $error("task count jumped by more than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.source_marked |-> out_o.changed)
    else $error("source marked without a carve");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("second item taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_busy |-> state_q == mbw_pkg::ST_CLEAR)
    else $error("cell store sweep overlaps item work");

endmodule
